// File: rtl/core/u8d_pkg.sv
package u8d_pkg;

  // Byte boundaries of the UTF-8 lead and continuation ranges
  localparam logic [7:0] CONT_MIN   = 8'h80;
  localparam logic [7:0] CONT_END   = 8'hC0;
  localparam logic [7:0] LEAD2_MIN  = 8'hC2;
  localparam logic [7:0] LEAD3_MIN  = 8'hE0;
  localparam logic [7:0] LEAD4_MIN  = 8'hF0;
  localparam logic [7:0] LEAD4_END  = 8'hF8;

  // Overlong check masks on the second byte
  localparam logic [5:0] OVL3_MASK  = 6'h20;
  localparam logic [5:0] OVL4_MASK  = 6'h30;

  localparam int CP_W      = 21;
  localparam int COUNT_W   = 3;
  localparam int PAYLOAD_W = 7;
  localparam int CONT_W    = 6;
  localparam int PART_W    = CP_W - CONT_W;

  localparam logic [COUNT_W-1:0] LEN1 = 3'd1;
  localparam logic [COUNT_W-1:0] LEN2 = 3'd2;
  localparam logic [COUNT_W-1:0] LEN3 = 3'd3;
  localparam logic [COUNT_W-1:0] LEN4 = 3'd4;

  typedef enum logic [2:0] {
    CLS_ASCII,
    CLS_CONT,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_BAD
  } byte_cls_t;

  // Classified byte: class plus the payload bits that class carries
  typedef struct packed {
    byte_cls_t              cls;
    logic [PAYLOAD_W-1:0]   payload;
  } cls_item_t;

endpackage

// File: rtl/core/u8d_front.sv
module u8d_front (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          in_byte,
  input  logic                push,
  output logic                full,
  output u8d_pkg::cls_item_t  item,
  output logic                item_valid,
  input  logic                item_take
);
  import u8d_pkg::*;

  cls_item_t   cls_in;
  cls_item_t   slot [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        do_push;

  // Classify the raw byte; decode state is not needed here
  always_comb begin
    cls_in.payload = '0;
    if (in_byte < CONT_MIN) begin
      cls_in.cls     = CLS_ASCII;
      cls_in.payload = in_byte[6:0];
    end else if (in_byte < CONT_END) begin
      cls_in.cls     = CLS_CONT;
      cls_in.payload = {1'b0, in_byte[5:0]};
    end else if (in_byte < LEAD2_MIN) begin
      cls_in.cls     = CLS_BAD;
    end else if (in_byte < LEAD3_MIN) begin
      cls_in.cls     = CLS_LEAD2;
      cls_in.payload = {2'b0, in_byte[4:0]};
    end else if (in_byte < LEAD4_MIN) begin
      cls_in.cls     = CLS_LEAD3;
      cls_in.payload = {3'b0, in_byte[3:0]};
    end else if (in_byte < LEAD4_END) begin
      cls_in.cls     = CLS_LEAD4;
      cls_in.payload = {4'b0, in_byte[2:0]};
    end else begin
      cls_in.cls     = CLS_BAD;
    end
  end

  assign full       = (count == 2'd2);
  assign do_push    = push && !full;
  assign item_valid = (count != 2'd0);
  assign item       = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= cls_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (item_take) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, item_take};
    end
  end

endmodule

// File: rtl/core/u8d_back.sv
module u8d_back (
  input  logic                         clk,
  input  logic                         rst,
  input  u8d_pkg::cls_item_t           item,
  input  logic                         item_valid,
  output logic                         item_take,
  output logic [u8d_pkg::CP_W-1:0]     code_point,
  output logic [u8d_pkg::COUNT_W-1:0]  byte_count,
  output logic                         error,
  output logic                         empty,
  input  logic                         pop
);
  import u8d_pkg::*;

  typedef struct packed {
    logic [CP_W-1:0]    cp;
    logic [COUNT_W-1:0] cnt;
    logic               err;
  } result_t;

  // Decode state
  logic [1:0]          bytes_left, bytes_left_next;
  logic [COUNT_W-1:0]  seq_length, seq_length_next;
  logic [PART_W-1:0]   partial_value, partial_value_next;
  logic                lead_payload_zero, lead_payload_zero_next;

  logic                emit;
  result_t             res;
  logic [CONT_W-1:0]   cont_bits;
  logic [CONT_W-1:0]   ovl_mask;

  // Result queue
  result_t             slot [2];
  logic                wr_ptr;
  logic                rd_ptr;
  logic [1:0]          count;
  logic                do_pop;
  logic                do_write;

  assign item_take = item_valid && (count != 2'd2);
  assign cont_bits = item.payload[CONT_W-1:0];
  assign ovl_mask  = (seq_length == LEN4) ? OVL4_MASK : OVL3_MASK;

  always_comb begin
    bytes_left_next        = bytes_left;
    seq_length_next        = seq_length;
    partial_value_next     = partial_value;
    lead_payload_zero_next = lead_payload_zero;
    emit                   = 1'b0;
    res                    = '0;
    if (bytes_left == 2'd0) begin
      unique case (item.cls)
        CLS_ASCII: begin
          emit    = 1'b1;
          res.cp  = CP_W'(item.payload);
          res.cnt = LEN1;
        end
        CLS_LEAD2: begin
          seq_length_next        = LEN2;
          bytes_left_next        = 2'd1;
          partial_value_next     = PART_W'(item.payload);
          lead_payload_zero_next = 1'b0;
        end
        CLS_LEAD3: begin
          seq_length_next        = LEN3;
          bytes_left_next        = 2'd2;
          partial_value_next     = PART_W'(item.payload);
          lead_payload_zero_next = (item.payload[3:0] == 4'd0);
        end
        CLS_LEAD4: begin
          seq_length_next        = LEN4;
          bytes_left_next        = 2'd3;
          partial_value_next     = PART_W'(item.payload);
          lead_payload_zero_next = (item.payload[2:0] == 3'd0);
        end
        default: begin
          emit    = 1'b1;
          res.err = 1'b1;
        end
      endcase
    end else if ((item.cls != CLS_CONT) ||
                 (lead_payload_zero && ((cont_bits & ovl_mask) == '0))) begin
      // bad continuation or overlong form: drop the sequence
      emit                   = 1'b1;
      res.err                = 1'b1;
      bytes_left_next        = 2'd0;
      seq_length_next        = '0;
      partial_value_next     = '0;
      lead_payload_zero_next = 1'b0;
    end else begin
      lead_payload_zero_next = 1'b0;
      partial_value_next     = PART_W'({partial_value, cont_bits});
      bytes_left_next        = bytes_left - 2'd1;
      if (bytes_left == 2'd1) begin
        emit                   = 1'b1;
        res.cp                 = {partial_value, cont_bits};
        res.cnt                = seq_length;
        seq_length_next        = '0;
        partial_value_next     = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left        <= 2'd0;
      seq_length        <= '0;
      partial_value     <= '0;
      lead_payload_zero <= 1'b0;
    end else if (item_take) begin
      bytes_left        <= bytes_left_next;
      seq_length        <= seq_length_next;
      partial_value     <= partial_value_next;
      lead_payload_zero <= lead_payload_zero_next;
    end
  end

  assign do_write   = item_take && emit;
  assign empty      = (count == 2'd0);
  assign do_pop     = pop && !empty;
  assign code_point = slot[rd_ptr].cp;
  assign byte_count = slot[rd_ptr].cnt;
  assign error      = slot[rd_ptr].err;

  always_ff @(posedge clk) begin
    if (do_write) begin
      slot[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_write) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_write} - {1'b0, do_pop};
    end
  end

endmodule

// File: rtl/core/utf8_stream_decoder.sv
// UTF-8 stream decoder: one raw byte in per transaction, at most one
// decoded result out per completed or failed sequence.
// Input side is a queue: drive in_byte and push; the transaction happens
// at a clock edge where push is high and full is low.
// Output side is a queue too: while empty is low, code_point, byte_count
// and error show the oldest result; pop high at an edge takes it.
// Errors (bad lead, bad continuation, overlong form) give one result with
// error set, code_point and byte_count zero, and leave the decoder idle.
// Order: a sequence's final byte waits in the front byte queue; the decode
// step then writes its result into the result queue, where it shows.
// Throughput: one byte per clock while the result queue has room; the
// back stage updates the decode state for each byte it takes.
// Stall: the two-entry result queue fills, the decode stage halts, the
// two-entry byte queue behind it fills, and full rises. Nothing is lost.
// Reset (rst, synchronous): both queues are emptied and the decoder is
// idle with no partial sequence; full and empty read 0 and 1 afterward.
module utf8_stream_decoder (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [7:0]                   in_byte,
  input  logic                         push,
  output logic                         full,
  output logic [u8d_pkg::CP_W-1:0]     code_point,
  output logic [u8d_pkg::COUNT_W-1:0]  byte_count,
  output logic                         error,
  output logic                         empty,
  input  logic                         pop
);
  import u8d_pkg::*;

  cls_item_t  item;
  logic       item_valid;
  logic       item_take;

  // Front: take bytes, classify, hold in a short queue
  u8d_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_byte    (in_byte),
    .push       (push),
    .full       (full),
    .item       (item),
    .item_valid (item_valid),
    .item_take  (item_take)
  );

  // Back: sequence tracking and the result queue
  u8d_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_take  (item_take),
    .code_point (code_point),
    .byte_count (byte_count),
    .error      (error),
    .empty      (empty),
    .pop        (pop)
  );

  // Error results carry no code point and no length
  assert property (@(posedge clk) disable iff (rst)
    (!empty && error) |-> (code_point == '0 && byte_count == '0))
    else $error("error result with nonzero payload");

  // Good results have a length from one to four
  assert property (@(posedge clk) disable iff (rst)
    (!empty && !error) |-> (byte_count != '0 && byte_count <= LEN4))
    else $error("bad byte_count on good result");

  // Single-byte results are ASCII, two-byte results are not overlong
  assert property (@(posedge clk) disable iff (rst)
    (!empty && !error && byte_count == LEN1) |-> (code_point < 21'h80))
    else $error("one-byte result out of ASCII range");

  assert property (@(posedge clk) disable iff (rst)
    (!empty && !error && byte_count == LEN2) |->
      (code_point >= 21'h80 && code_point < 21'h800))
    else $error("two-byte result out of range");

  // Reset leaves both queues empty
  assert property (@(posedge clk) $past(rst) |-> (empty && !full))
    else $error("queues not empty after reset");

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import u8d_pkg::*;

  // Watchdog: longest legal quiet stretch is the receiver hold-off
  // plus a sender gap, well under this.
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int SHOW_MAX    = 10;

  // One decoded result as the DUT presents it
  typedef struct packed {
    logic [CP_W-1:0]    cp;
    logic [COUNT_W-1:0] len;
    logic               err;
  } decoded_t;

  logic                clk;
  logic                rst;
  logic [7:0]          in_byte = 8'h00;
  logic                push    = 1'b0;
  logic                full;
  logic [CP_W-1:0]     code_point;
  logic [COUNT_W-1:0]  byte_count;
  logic                error;
  logic                empty;
  logic                pop     = 1'b0;

  utf8_stream_decoder u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_byte    (in_byte),
    .push       (push),
    .full       (full),
    .code_point (code_point),
    .byte_count (byte_count),
    .error      (error),
    .empty      (empty),
    .pop        (pop)
  );

  // Raw bytes waiting to be offered, and decoded results still owed by the DUT
  logic [7:0] stream_bytes[$];
  decoded_t   expected_points[$];

  int fail_count  = 0;
  int quiet_count = 0;
  int hold_req    = 0;

  // ---------------------------------------------------------------------------
  // Decoder model: own copy of the sequence state.
  //   dec_left      continuation bytes still due (0 = idle)
  //   dec_len       length of the open sequence
  //   dec_acc       code point bits gathered so far
  //   dec_ovl_check lead payload was zero, second byte not yet checked
  // ---------------------------------------------------------------------------
  logic [1:0]         dec_left;
  logic [COUNT_W-1:0] dec_len;
  logic [CP_W-1:0]    dec_acc;
  logic               dec_ovl_check;

  function automatic void reset_decoder();
    dec_left      = 2'd0;
    dec_len       = '0;
    dec_acc       = '0;
    dec_ovl_check = 1'b0;
  endfunction

  function automatic void post_result(logic [CP_W-1:0] cp, logic [COUNT_W-1:0] len,
                                      logic err);
    decoded_t r;
    r.cp  = cp;
    r.len = len;
    r.err = err;
    expected_points.push_back(r);
  endfunction

  function automatic void decode_byte(logic [7:0] b);
    logic [5:0] need;
    need = (dec_len == LEN4) ? OVL4_MASK : OVL3_MASK;
    if (dec_left == 2'd0) begin
      if (b < CONT_MIN) begin
        post_result({13'd0, b}, LEN1, 1'b0);
      end else if (b >= LEAD2_MIN && b < LEAD3_MIN) begin
        dec_len       = LEN2;
        dec_left      = 2'd1;
        dec_acc       = {16'd0, b[4:0]};
        dec_ovl_check = 1'b0;
      end else if (b >= LEAD3_MIN && b < LEAD4_MIN) begin
        dec_len       = LEN3;
        dec_left      = 2'd2;
        dec_acc       = {17'd0, b[3:0]};
        dec_ovl_check = (b[3:0] == 4'd0);
      end else if (b >= LEAD4_MIN && b < LEAD4_END) begin
        dec_len       = LEN4;
        dec_left      = 2'd3;
        dec_acc       = {18'd0, b[2:0]};
        dec_ovl_check = (b[2:0] == 3'd0);
      end else begin
        // bad lead: continuation byte, C0/C1 or F8 and up
        reset_decoder();
        post_result('0, '0, 1'b1);
      end
    end else if (b < CONT_MIN || b >= CONT_END) begin
      // bad continuation: byte is dropped, decoder goes idle
      reset_decoder();
      post_result('0, '0, 1'b1);
    end else if (dec_ovl_check && (b[5:0] & need) == 6'd0) begin
      // overlong 3- or 4-byte form, caught on the second byte
      reset_decoder();
      post_result('0, '0, 1'b1);
    end else begin
      dec_ovl_check = 1'b0;
      dec_acc       = {dec_acc[PART_W-1:0], b[5:0]};
      dec_left      = dec_left - 2'd1;
      if (dec_left == 2'd0) begin
        post_result(dec_acc, dec_len, 1'b0);
        reset_decoder();
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  function automatic logic [7:0] lead_byte(int len);
    case (len)
      1:       return 8'($urandom_range(8'h00, 8'h7F));
      2:       return 8'($urandom_range(LEAD2_MIN, 8'hDF));
      3:       return 8'($urandom_range(LEAD3_MIN, 8'hEF));
      default: return 8'($urandom_range(LEAD4_MIN, 8'hF7));
    endcase
  endfunction

  // Mostly well-formed sequences with random payload; the rest is noise,
  // cut-off sequences and possibly-overlong E0/F0 forms.
  task automatic queue_random_stream(input int n_bytes);
    int         added;
    int         kind;
    int         len;
    int         keep;
    logic [7:0] lead;
    logic [7:0] b;
    added = 0;
    while (added < n_bytes) begin
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
        len  = $urandom_range(1, 4);
        lead = lead_byte(len);
        stream_bytes.push_back(lead);
        added++;
        for (int i = 1; i < len; i++) begin
          b = cont_byte();
          if (i == 1 && lead == LEAD3_MIN) b = 8'hA0 | 8'($urandom_range(0, 31));
          if (i == 1 && lead == LEAD4_MIN) b = 8'($urandom_range(8'h90, 8'hBF));
          stream_bytes.push_back(b);
          added++;
        end
      end else if (kind < 88) begin
        stream_bytes.push_back(8'($urandom_range(0, 255)));
        added++;
      end else if (kind < 94) begin
        // sequence broken off early by an arbitrary byte
        len  = $urandom_range(2, 4);
        keep = $urandom_range(0, len - 2);
        stream_bytes.push_back(lead_byte(len));
        added++;
        for (int i = 0; i < keep; i++) begin
          stream_bytes.push_back(cont_byte());
          added++;
        end
        stream_bytes.push_back(8'($urandom_range(0, 255)));
        added++;
      end else begin
        // zero-payload lead with an unchecked second byte
        len = $urandom_range(3, 4);
        stream_bytes.push_back(len == 3 ? LEAD3_MIN : LEAD4_MIN);
        added++;
        for (int i = 1; i < len; i++) begin
          stream_bytes.push_back(cont_byte());
          added++;
        end
      end
    end
  endtask

  // Sender pause: hold off until every queued byte is taken and every
  // owed result has been popped. Sampled mid-cycle so the clocked
  // processes of the last edge have settled.
  task automatic wait_drained();
    do @(negedge clk);
    while (stream_bytes.size() != 0 || push || expected_points.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Clock and reset
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Sender: offers bytes in bursts with random gaps. push stays up while
  // full holds the transaction off.
  // ---------------------------------------------------------------------------
  int burst_left;
  int gap_left;

  always @(posedge clk) begin : drive_proc
    logic       nxt_push;
    logic [7:0] nxt_byte;
    if (rst) begin
      push       <= 1'b0;
      in_byte    <= 8'h00;
      burst_left = 1;
      gap_left   = 0;
      reset_decoder();
    end else begin
      nxt_push = push;
      nxt_byte = in_byte;
      if (push && !full) begin
        decode_byte(in_byte);
        nxt_push = 1'b0;
      end
      if (!nxt_push) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (stream_bytes.size() != 0) begin
          nxt_byte = stream_bytes.pop_front();
          nxt_push = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 48);
            // about a third of bursts run straight into the next one
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
      push    <= nxt_push;
      in_byte <= nxt_byte;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: cycles through pop patterns (always, coin flip, sparse,
  // periodic). A hold-off request keeps pop low while a counter loaded with
  // HOLD_CYCLES runs down, so both internal queues fill and full rises.
  // ---------------------------------------------------------------------------
  int          hold_served;
  int          hold_left;
  logic [15:0] rx_tick;

  always @(posedge clk) begin : recv_proc
    logic nxt_pop;
    if (rst) begin
      pop         <= 1'b0;
      hold_served <= 0;
      hold_left   <= 0;
      rx_tick     <= '0;
    end else begin
      rx_tick <= rx_tick + 16'd1;
      if (hold_served != hold_req) begin
        hold_served <= hold_req;
        hold_left   <= HOLD_CYCLES;
        nxt_pop     = 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        nxt_pop   = 1'b0;
      end else begin
        case (rx_tick[9:8])
          2'd0:    nxt_pop = 1'b1;
          2'd1:    nxt_pop = 1'($urandom_range(0, 1));
          2'd2:    nxt_pop = ($urandom_range(0, 3) == 0);
          default: nxt_pop = (rx_tick[2:0] != 3'd0);
        endcase
      end
      pop <= nxt_pop;
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: every popped result against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_proc
    decoded_t want;
    if (!rst && pop && !empty) begin
      if (expected_points.size() == 0) begin
        fail_count++;
        if (fail_count <= SHOW_MAX)
          $display("unexpected result: code_point=%h byte_count=%0d error=%b",
                   code_point, byte_count, error);
      end else begin
        want = expected_points.pop_front();
        if (code_point !== want.cp || byte_count !== want.len || error !== want.err) begin
          fail_count++;
          if (fail_count <= SHOW_MAX)
            $display("mismatch: exp cp=%h cnt=%0d err=%b  got cp=%h cnt=%0d err=%b",
                     want.cp, want.len, want.err, code_point, byte_count, error);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: quiet cycles with no transaction on either side
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_count <= 0;
    end else begin
      quiet_count <= quiet_count + 1;
      if (quiet_count >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    // Directed bytes, first to last:
    //   ASCII extremes; shortest and longest 2- and 4-byte forms (up to
    //   0x1FFFFF) and the shortest 3-byte form; bad leads; a bad
    //   continuation that swallows an ASCII byte; overlong E0 and F0 forms.
    logic [8*27-1:0] directed;
    directed = {8'h00, 8'h7F,
                8'hC2, 8'h80, 8'hDF, 8'hBF,
                8'hE0, 8'hA0, 8'h80,
                8'hF0, 8'h90, 8'h80, 8'h80,
                8'hF7, 8'hBF, 8'hBF, 8'hBF,
                8'h80, 8'hC1, 8'hF8, 8'hFF,
                8'hC3, 8'h41,
                8'hE0, 8'h9F,
                8'hF0, 8'h8F};
    @(negedge rst);
    for (int i = 26; i >= 0; i--)
      stream_bytes.push_back(directed[i*8 +: 8]);
    wait_drained();

    queue_random_stream(900);

    // Pressure: receiver stalls while the sender keeps offering
    @(posedge clk);
    hold_req <= hold_req + 1;
    queue_random_stream(150);
    wait_drained();

    queue_random_stream(870);
    wait_drained();

    repeat (20) @(posedge clk);
    fail_count += expected_points.size();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/u8d_pkg.sv
rtl/core/u8d_front.sv
rtl/core/u8d_back.sv
rtl/core/utf8_stream_decoder.sv
dv/testbench.sv
